FILE: hw/rtl/kdp_pkg.sv
// shared types and constants of the key double-press classifier
// no dependencies; imported by every other file of the block
package kdp_pkg;

    localparam int KEY_COUNT   = 256;
    localparam int ADDR_W      = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
    localparam int KEY_W       = 8;
    localparam int TIME_W      = 32;
    localparam int WIN_W       = 16;
    localparam int CODE_W      = 3;
    localparam int CNT_W       = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd500;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TIME_W-1:0] stamp_t;
    typedef logic [WIN_W-1:0]  window_t;

    typedef enum logic [CODE_W-1:0] {
        EV_NONE         = 3'd0,
        EV_DOWN         = 3'd1,
        EV_UP           = 3'd2,
        EV_PRESS        = 3'd3,
        EV_DOUBLE_DOWN  = 3'd4,
        EV_DOUBLE_UP    = 3'd5,
        EV_DOUBLE_PRESS = 3'd6
    } code_t;

    localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
    localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

    // per-key tracking state
    typedef struct packed {
        logic             last_level;
        logic             double_mode;
        logic [CNT_W-1:0] click_count;
        stamp_t           click_start_ms;
    } key_state_t;

    // one classified result item
    typedef struct packed {
        key_t  key;
        code_t code;
    } ev_t;

endpackage

FILE: hw/rtl/kdp_if.sv
// valid/ready channel interfaces for key samples and key events
// depends on kdp_pkg for the payload widths
interface kdp_sample_if;
    import kdp_pkg::*;

    logic   valid;
    logic   ready;
    key_t   key_index;
    logic   pressed;
    stamp_t now_ms;

    modport source (output valid, output key_index, output pressed, output now_ms,
                    input ready);
    modport sink   (input valid, input key_index, input pressed, input now_ms,
                    output ready);
endinterface

interface kdp_event_if;
    import kdp_pkg::*;

    logic              valid;
    logic              ready;
    key_t              event_key;
    logic [CODE_W-1:0] event_code;

    modport source (output valid, output event_key, output event_code, input ready);
    modport sink   (input valid, input event_key, input event_code, output ready);
endinterface

FILE: hw/rtl/key_event_double_press_classifier_unit.sv
// key double-press classifier: one result item per key sample item.
// path: a sample passes the sample stage registers, the item queue and the output register.
// throughput: one item per cycle unless the event side holds off, set by the per-key state
//   memory read-modify-write (registered read at accept, write on advance, one-deep write bypass).
// reset: per-key valid flags clear at once, so no clearing pass; window resets to 500 ms.
// depends on kdp_pkg, kdp_if, kdp_front, kdp_queue, kdp_back
module key_event_double_press_classifier_unit (
    input  logic             clk,
    input  logic             rst_n,
    kdp_sample_if.sink       samples,
    kdp_event_if.source      events,
    input  logic             cfg_we,
    input  kdp_pkg::window_t cfg_wdata
);
    import kdp_pkg::*;

    logic push_valid;
    logic push_ready;
    ev_t  push_item;
    logic pop_valid;
    logic pop_ready;
    ev_t  pop_item;

    kdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .samples    (samples),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    kdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    kdp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready),
        .events     (events)
    );

endmodule

FILE: hw/rtl/kdp_front.sv
// front end: takes key samples, keeps per-key state in a memory and classifies
// depends on kdp_pkg and kdp_sample_if
module kdp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    kdp_sample_if.sink           samples,
    input  logic                 cfg_we,
    input  kdp_pkg::window_t     cfg_wdata,
    output logic                 push_valid,
    output kdp_pkg::ev_t         push_item,
    input  logic                 push_ready
);
    import kdp_pkg::*;

    window_t             window_reg;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    key_t                s1_key_reg;
    addr_t               s1_addr_reg;
    logic                s1_pressed_reg;
    stamp_t              s1_now_reg;
    logic                s1_in_range_reg;
    logic [KEY_COUNT-1:0] entry_valid_reg;

    key_state_t          state_mem [KEY_COUNT];
    key_state_t          mem_rd_reg;
    logic                ent_valid_reg;
    logic                byp_hit_reg;
    key_state_t          byp_data_reg;

    logic                accept;
    logic                advance;
    logic                wr_en;
    key_state_t          wr_data;
    code_t               code;
    logic [31:0]         in_key_wide;
    addr_t               in_addr;
    logic                in_range;

    assign samples.ready = !s1_valid_reg || push_ready;
    assign accept        = samples.valid && samples.ready;
    assign advance       = s1_valid_reg && push_ready;
    assign wr_en         = advance && s1_in_range_reg;

    assign in_key_wide = 32'(samples.key_index);
    assign in_addr     = in_key_wide[ADDR_W-1:0];
    assign in_range    = in_key_wide < 32'(KEY_COUNT);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg      <= WINDOW_RESET;
            s1_valid_reg    <= 1'b0;
            entry_valid_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            s1_valid_reg <= s1_valid_next;
            if (wr_en)
            begin
                entry_valid_reg[s1_addr_reg] <= 1'b1;
            end
        end
    end

    // state memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            state_mem[s1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            mem_rd_reg <= state_mem[in_addr];
        end
    end

    // sample stage payload; a write at the read edge is bypassed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_key_reg      <= samples.key_index;
            s1_addr_reg     <= in_addr;
            s1_pressed_reg  <= samples.pressed;
            s1_now_reg      <= samples.now_ms;
            s1_in_range_reg <= in_range;
            ent_valid_reg   <= entry_valid_reg[in_addr];
            byp_hit_reg     <= wr_en && (s1_addr_reg == in_addr);
            byp_data_reg    <= wr_data;
        end
    end

    always_comb
    begin
        key_state_t st;
        key_state_t nx;
        logic       prev;
        logic       cur;
        stamp_t     age;

        if (byp_hit_reg)
        begin
            st = byp_data_reg;
        end
        else if (ent_valid_reg)
        begin
            st = mem_rd_reg;
        end
        else
        begin
            st = '0;
        end

        prev = st.last_level;
        cur  = s1_pressed_reg;
        nx   = st;
        code = EV_NONE;

        if (!st.double_mode)
        begin
            if (!prev && cur)
            begin
                code = EV_DOWN;
            end
            else if (prev && !cur)
            begin
                code = EV_UP;
            end
            else if (prev && cur)
            begin
                code = EV_PRESS;
            end
        end
        else
        begin
            if (prev && !cur)
            begin
                code = EV_DOUBLE_UP;
            end
            else if (prev && cur)
            begin
                code = EV_DOUBLE_PRESS;
            end
            else
            begin
                // double mode ends once the key is seen released
                nx.double_mode = 1'b0;
            end
        end
        nx.last_level = cur;

        // window expiry, wrapping time difference
        age = s1_now_reg - st.click_start_ms;
        if ((st.click_count != CNT_ZERO) && (age >= stamp_t'(window_reg)))
        begin
            nx.double_mode    = 1'b0;
            nx.click_count    = CNT_ZERO;
            nx.click_start_ms = '0;
        end

        if (code == EV_DOWN)
        begin
            if (nx.click_count == CNT_TWO)
            begin
                code              = EV_DOUBLE_DOWN;
                nx.double_mode    = 1'b1;
                nx.click_count    = CNT_ZERO;
                nx.click_start_ms = '0;
            end
            else
            begin
                nx.click_start_ms = s1_now_reg;
                nx.click_count    = nx.click_count + CNT_ONE;
            end
        end
        else if ((nx.click_count == CNT_ONE) && (code == EV_UP))
        begin
            nx.click_count = CNT_TWO;
        end

        wr_data = nx;
    end

    assign push_valid     = s1_valid_reg;
    assign push_item.key  = s1_key_reg;
    assign push_item.code = s1_in_range_reg ? code : EV_NONE;

endmodule

FILE: hw/rtl/kdp_queue.sv
// short item queue between the classifier front end and the output stage
// depends on kdp_pkg
module kdp_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  kdp_pkg::ev_t push_item,
    output logic         push_ready,
    output logic         pop_valid,
    output kdp_pkg::ev_t pop_item,
    input  logic         pop_ready
);
    import kdp_pkg::*;

    ev_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hw/rtl/kdp_back.sv
// output stage: registers queued items onto the event channel
// depends on kdp_pkg and kdp_event_if
module kdp_back (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         pop_valid,
    input  kdp_pkg::ev_t pop_item,
    output logic         pop_ready,
    kdp_event_if.source  events
);
    import kdp_pkg::*;

    logic out_valid_reg;
    logic out_valid_next;
    ev_t  out_item_reg;
    logic load;

    // refill whenever the held item is empty or leaves this cycle
    assign pop_ready = !out_valid_reg || events.ready;
    assign load      = pop_valid && pop_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (events.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_item_reg <= pop_item;
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.event_key  = out_item_reg.key;
    assign events.event_code = out_item_reg.code;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for the key double-press classifier: directed and random key samples
// depends on kdp_pkg, kdp_if and key_event_double_press_classifier_unit
module testbench;
    import kdp_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 120;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 268;
    localparam int MAX_PRINTS     = 50;

    // per-key tracker and store of due event items
    class key_event_board;
        bit                last_level[KEY_COUNT];
        bit                double_mode[KEY_COUNT];
        bit [CNT_W-1:0]    clicks[KEY_COUNT];
        bit [TIME_W-1:0]   start_ms[KEY_COUNT];
        window_t           window;
        ev_t               due_events[$];
        int                mismatches;
        int                checked;

        function new();
            window = WINDOW_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function int pending();
            return due_events.size();
        endfunction

        // classify one accepted sample and queue the event it must produce
        function void note_sample(key_t k, logic p, stamp_t now);
            code_t       c;
            int unsigned i;
            ev_t         ev;
            i = k;
            c = EV_NONE;
            if (i < KEY_COUNT)
            begin
                if (!double_mode[i])
                begin
                    if (!last_level[i] && p)
                        c = EV_DOWN;
                    else if (last_level[i] && !p)
                        c = EV_UP;
                    else if (last_level[i] && p)
                        c = EV_PRESS;
                end
                else if (last_level[i] && !p)
                    c = EV_DOUBLE_UP;
                else if (last_level[i] && p)
                    c = EV_DOUBLE_PRESS;
                else
                    double_mode[i] = 1'b0;
                last_level[i] = p;

                // window check uses wrapping 32-bit distance
                if (clicks[i] != CNT_ZERO &&
                    stamp_t'(now - start_ms[i]) >= {{(TIME_W-WIN_W){1'b0}}, window})
                begin
                    double_mode[i] = 1'b0;
                    clicks[i] = CNT_ZERO;
                    start_ms[i] = '0;
                end

                if (c == EV_DOWN)
                begin
                    if (clicks[i] == CNT_TWO)
                    begin
                        c = EV_DOUBLE_DOWN;
                        double_mode[i] = 1'b1;
                        clicks[i] = CNT_ZERO;
                        start_ms[i] = '0;
                    end
                    else
                    begin
                        start_ms[i] = now;
                        clicks[i] = clicks[i] + 1'b1;
                    end
                end
                else if (clicks[i] == CNT_ONE && c == EV_UP)
                begin
                    clicks[i] = CNT_TWO;
                end
            end
            ev.key = k;
            ev.code = c;
            due_events.push_back(ev);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("%0t mismatch: %s", $realtime, msg);
        endtask

        task check_event(key_t k, logic [CODE_W-1:0] c);
            ev_t want;
            if (due_events.size() == 0)
            begin
                report_mismatch($sformatf("event key %0d code %0d with nothing due", k, c));
                return;
            end
            want = due_events.pop_front();
            checked++;
            if (k !== want.key)
                report_mismatch($sformatf("event_key %0d, want %0d", k, want.key));
            if (c !== want.code)
                report_mismatch($sformatf("key %0d event_code %0d, want %0d (%s)",
                                          want.key, c, want.code, want.code.name()));
        endtask
    endclass

    logic    clk = 1'b0;
    logic    rst_n;
    logic    cfg_we;
    window_t cfg_wdata;

    kdp_sample_if smp ();
    kdp_event_if  evt ();

    key_event_double_press_classifier_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (smp),
        .events    (evt),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    key_event_board board;
    bit             idling_on;
    bit             long_hold_req;
    bit             held[KEY_COUNT];
    stamp_t         clock_ms;
    int             samples_sent;
    int             windows_used;
    int             stall_cycles;

    // result side: random ready bursts plus one long hold-off on request
    initial
    begin
        evt.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                evt.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_req = 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                evt.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            else
            begin
                evt.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && evt.valid && evt.ready)
            board.check_event(evt.event_key, evt.event_code);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (smp.valid && smp.ready) || (evt.valid && evt.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles, %0d events still due",
                     stall_cycles, board.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_sample(input key_t k, input logic p, input stamp_t now);
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        smp.valid     <= 1'b1;
        smp.key_index <= k;
        smp.pressed   <= p;
        smp.now_ms    <= now;
        @(posedge clk);
        while (!smp.ready)
            @(posedge clk);
        board.note_sample(k, p, now);
        samples_sent++;
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input window_t w);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.window = w;
        windows_used++;
    endtask

    // a few busy keys so down/up/down runs form, with some noise on any key
    task automatic random_phase(input int count, input bit quiet);
        key_t        keys[4];
        key_t        k;
        logic        p;
        int unsigned w;
        int unsigned roll;
        for (int j = 0; j < 4; j++)
            keys[j] = key_t'($urandom_range(0, 255));
        w = board.window;
        for (int i = 0; i < count; i++)
        begin
            if (i % 45 == 0)
                idling_on = !quiet && ($urandom_range(0, 2) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 88)
            begin
                k = keys[$urandom_range(0, 3)];
                p = ($urandom_range(0, 9) < 7) ? !held[k] : held[k];
            end
            else
            begin
                k = key_t'($urandom_range(0, 255));
                p = 1'($urandom_range(0, 1));
            end
            held[k] = p;
            roll = $urandom_range(0, 99);
            if (roll < 70)
                clock_ms += $urandom_range(0, w / 3 + 1);
            else if (roll < 96)
                clock_ms += $urandom_range(0, 2 * w + 2);
            else
                clock_ms = $urandom();
            send_sample(k, p, clock_ms);
        end
    endtask

    initial
    begin
        board = new();
        samples_sent = 0;
        windows_used = 1;
        stall_cycles = 0;
        idling_on = 1'b0;
        long_hold_req = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        smp.valid     <= 1'b0;
        smp.key_index <= '0;
        smp.pressed   <= 1'b0;
        smp.now_ms    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full double-press cycle on key 0 with the reset window
        send_sample(8'd0, 1'b0, 32'd1000);
        send_sample(8'd0, 1'b1, 32'd1010);
        send_sample(8'd0, 1'b1, 32'd1020);
        send_sample(8'd0, 1'b0, 32'd1030);
        send_sample(8'd0, 1'b1, 32'd1040);
        send_sample(8'd0, 1'b1, 32'd1050);
        send_sample(8'd0, 1'b0, 32'd1060);
        // down edge in double mode after release gives none and leaves double mode
        send_sample(8'd0, 1'b1, 32'd1070);
        send_sample(8'd0, 1'b0, 32'd1080);
        // window runs out exactly at its length
        send_sample(8'd255, 1'b1, 32'd2000);
        send_sample(8'd255, 1'b0, 32'd2499);
        send_sample(8'd255, 1'b1, 32'd2500);
        send_sample(8'd255, 1'b0, 32'd2600);
        send_sample(8'd255, 1'b1, 32'd2700);
        // double press across the time stamp wrap
        send_sample(8'd7, 1'b1, 32'hFFFF_FF00);
        send_sample(8'd7, 1'b0, 32'hFFFF_FF80);
        send_sample(8'd7, 1'b1, 32'h0000_0010);
        send_sample(8'd7, 1'b0, 32'h0000_0020);
        // leave double mode again, then a new first click after a long gap
        send_sample(8'd7, 1'b1, 32'h0000_0030);
        send_sample(8'd7, 1'b0, 32'h0000_0040);
        send_sample(8'd7, 1'b1, 32'h8000_0000);
        for (int j = 0; j < KEY_COUNT; j++)
            held[j] = board.last_level[j];
        clock_ms = 32'd5000;

        random_phase(PHASE_ITEMS, 1'b0);
        write_window(16'd0);
        random_phase(PHASE_ITEMS, 1'b0);
        write_window(16'hFFFF);
        long_hold_req = 1'b1;
        random_phase(PHASE_ITEMS, 1'b0);
        write_window(16'd1);
        random_phase(PHASE_ITEMS, 1'b0);
        write_window(16'd200);
        random_phase(PHASE_ITEMS, 1'b0);
        write_window(window_t'($urandom_range(2, 65534)));
        random_phase(PHASE_ITEMS, 1'b0);
        write_window(WINDOW_RESET);
        random_phase(PHASE_ITEMS, 1'b1);
        drain();

        $display("%0d key samples over %0d window settings, %0d events compared",
                 samples_sent, windows_used, board.checked);
        if (board.mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches", board.mismatches);
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/kdp_pkg.sv
hw/rtl/kdp_if.sv
hw/rtl/kdp_front.sv
hw/rtl/kdp_queue.sv
hw/rtl/kdp_back.sv
hw/rtl/key_event_double_press_classifier_unit.sv
tb/sv/testbench.sv
